[rtl/sbd_pkg.sv]
`default_nettype none

package sbd_pkg;

  // Bank geometry
  localparam int NUM_SWITCHES = 16;
  localparam int COUNT_BITS   = 4;
  localparam int SLOT_BITS    = 4;
  localparam int WORD_BITS    = 16;
  localparam int DUR_BITS     = 64;
  localparam int PAIR_BITS    = 3;
  localparam int CFG_IDX_BITS = 3;

  // Safe/active pair contact positions in the scan word
  localparam int BIT_SAFE   = 7;
  localparam int BIT_ACTIVE = 6;

  localparam logic [PAIR_BITS-1:0] PAIR_TICKS_RESET = PAIR_BITS'(6);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ENABLED    = 3'd0,
    REG_WAIT_MODE  = 3'd1,
    REG_NOTIFY     = 3'd2,
    REG_CLOSE_DUR  = 3'd3,
    REG_OPEN_DUR   = 3'd4,
    REG_PAIR_TICKS = 3'd5
  } cfg_reg_t;

  // Per-switch debounce phase
  typedef enum logic [1:0] {
    PH_OPEN    = 2'd0,
    PH_CLOSED  = 2'd1,
    PH_OPENING = 2'd2,
    PH_CLOSING = 2'd3
  } phase_t;

  // Safe/active pair mode
  typedef enum logic [1:0] {
    PR_UNDEF    = 2'd0,
    PR_SAFE     = 2'd1,
    PR_ACTIVE   = 2'd2,
    PR_DEBOUNCE = 2'd3
  } pair_mode_t;

  // Inputs to one switch cell for the current transfer
  typedef struct packed {
    logic                  is_tick;
    logic                  changed;
    logic                  enabled;
    logic                  wait_mode;
    logic                  raw_open;
    logic [COUNT_BITS-1:0] dur_close;
    logic [COUNT_BITS-1:0] dur_open;
  } sbd_cell_ctl_t;

  // Shown-bit update requested by one switch cell
  typedef struct packed {
    logic show_we;
    logic show_open;
    logic show_note;
  } sbd_cell_res_t;

endpackage

`default_nettype wire

[rtl/sbd_if.sv]
`default_nettype none

// Scan word channel
interface sbd_in_if;
  import sbd_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] change_word;

  modport source (output valid, output change_word, input ready);
  modport sink   (input valid, input change_word, output ready);
endinterface

// Debounced status channel
interface sbd_out_if;
  import sbd_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] shown_state;
  logic [WORD_BITS-1:0] notify_bits;
  logic                 pair_active;
  logic                 pair_went_active;
  logic                 pair_went_safe;

  modport source (output valid, output shown_state, output notify_bits,
                  output pair_active, output pair_went_active,
                  output pair_went_safe, input ready);
  modport sink   (input valid, input shown_state, input notify_bits,
                  input pair_active, input pair_went_active,
                  input pair_went_safe, output ready);
endinterface

`default_nettype wire

[rtl/sbd_switch.sv]
`default_nettype none

// One debounced switch: phase and tick count, plus its shown-bit request
module sbd_switch (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   advance,
  input  wire sbd_pkg::sbd_cell_ctl_t ctl,
  output sbd_pkg::sbd_cell_res_t      res
);
  import sbd_pkg::*;

  phase_t                phase, phase_next;
  logic [COUNT_BITS-1:0] cnt, cnt_next;
  logic [COUNT_BITS-1:0] cnt_dec;
  logic                  debouncing;

  assign debouncing = (phase == PH_OPENING) || (phase == PH_CLOSING);
  assign cnt_dec    = (cnt != '0) ? cnt - COUNT_BITS'(1) : '0;

  // Next phase, count and shown-bit request
  always_comb begin
    phase_next    = phase;
    cnt_next      = cnt;
    res.show_we   = 1'b0;
    res.show_open = 1'b0;
    res.show_note = 1'b0;
    if (ctl.enabled && ctl.is_tick) begin
      if (debouncing) begin
        cnt_next = cnt_dec;
        if (cnt_dec == '0) begin
          if (!ctl.raw_open) begin
            phase_next = PH_CLOSED;
            if ((phase == PH_OPENING) != ctl.wait_mode) begin
              res.show_we   = 1'b1;
              res.show_note = 1'b1;
            end
          end else begin
            phase_next = PH_OPEN;
            if ((phase == PH_CLOSING) != ctl.wait_mode) begin
              res.show_we   = 1'b1;
              res.show_open = 1'b1;
              res.show_note = 1'b1;
            end
          end
        end
      end
    end else if (ctl.enabled && ctl.changed) begin
      unique case (phase)
        PH_OPEN: begin
          if (!ctl.raw_open) begin
            if (ctl.dur_close == '0) begin
              res.show_we   = 1'b1;
              res.show_note = 1'b1;
              phase_next    = PH_CLOSED;
            end else begin
              res.show_we   = !ctl.wait_mode;
              res.show_note = !ctl.wait_mode;
              phase_next    = PH_CLOSING;
              cnt_next      = ctl.dur_close;
            end
          end else begin
            // toggle landed back on the settled value: quiet refresh
            res.show_we   = 1'b1;
            res.show_open = 1'b1;
          end
        end
        PH_CLOSED: begin
          if (ctl.raw_open) begin
            if (ctl.dur_open == '0) begin
              res.show_we   = 1'b1;
              res.show_open = 1'b1;
              res.show_note = 1'b1;
              phase_next    = PH_OPEN;
            end else begin
              res.show_we   = !ctl.wait_mode;
              res.show_open = 1'b1;
              res.show_note = !ctl.wait_mode;
              phase_next    = PH_OPENING;
              cnt_next      = ctl.dur_open;
            end
          end else begin
            res.show_we = 1'b1;
          end
        end
        PH_OPENING: cnt_next = ctl.dur_open;
        PH_CLOSING: cnt_next = ctl.dur_close;
        default:    cnt_next = cnt;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_CLOSED;
      cnt   <= '0;
    end else if (advance) begin
      phase <= phase_next;
      cnt   <= cnt_next;
    end
  end

endmodule

`default_nettype wire

[rtl/switch_bank_debouncer.sv]
`default_nettype none

// Channel   Role   Payload
// scan      sink   change_word (nonzero: toggled contacts, zero: one tick)
// status    source shown_state, notify_bits, pair_active,
//                  pair_went_active, pair_went_safe
// cfg_*     write  cfg_index selects register, cfg_data carries value
//
// One scan word per cycle while the status register is empty or being taken; its status appears in the next cycle.
// All switch cells and the pair machine update in the accepting cycle.
// Synchronous reset: switches closed, counts zero, pair undefined, no status.
// The status register stalls on status.ready; scan.ready stays high while
// the held status is taken in the same cycle.
module switch_bank_debouncer (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [sbd_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire logic [sbd_pkg::DUR_BITS-1:0]        cfg_data,
  sbd_in_if.sink                                   scan,
  sbd_out_if.source                                status
);
  import sbd_pkg::*;

  // Configuration
  logic [WORD_BITS-1:0] enabled_mask, wait_mode_mask, notify_mask;
  logic [DUR_BITS-1:0]  close_durations, open_durations;
  logic [PAIR_BITS-1:0] pair_debounce_ticks;

  // Bank state
  logic [WORD_BITS-1:0] raw_contacts, raw_next;
  logic [WORD_BITS-1:0] shown_contacts, shown_next;
  logic [WORD_BITS-1:0] notes;
  pair_mode_t           pair_mode, pair_mode_next;
  logic [PAIR_BITS-1:0] pair_ticks_left, pair_ticks_next;
  logic                 went_active, went_safe;

  // Output register
  logic                 out_valid;

  logic                 accept;
  logic                 is_tick;
  logic [1:0]           swb;
  pair_mode_t           pm;

  sbd_cell_ctl_t        ctl [NUM_SWITCHES];
  sbd_cell_res_t        res [NUM_SWITCHES];

  assign scan.ready = !out_valid || status.ready;
  assign accept     = scan.valid && scan.ready;
  assign is_tick    = (scan.change_word == '0);
  assign raw_next   = raw_contacts ^ scan.change_word;
  assign swb        = {raw_next[BIT_SAFE], raw_next[BIT_ACTIVE]};

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled_mask        <= '0;
      wait_mode_mask      <= '0;
      notify_mask         <= '0;
      close_durations     <= '0;
      open_durations      <= '0;
      pair_debounce_ticks <= PAIR_TICKS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLED:    enabled_mask        <= cfg_data[WORD_BITS-1:0];
        REG_WAIT_MODE:  wait_mode_mask      <= cfg_data[WORD_BITS-1:0];
        REG_NOTIFY:     notify_mask         <= cfg_data[WORD_BITS-1:0];
        REG_CLOSE_DUR:  close_durations     <= cfg_data;
        REG_OPEN_DUR:   open_durations      <= cfg_data;
        REG_PAIR_TICKS: pair_debounce_ticks <= cfg_data[PAIR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Switch cells
  for (genvar i = 0; i < NUM_SWITCHES; i++) begin : g_sw
    assign ctl[i].is_tick   = is_tick;
    assign ctl[i].changed   = scan.change_word[i];
    assign ctl[i].enabled   = enabled_mask[i];
    assign ctl[i].wait_mode = wait_mode_mask[i];
    assign ctl[i].raw_open  = raw_next[i];
    assign ctl[i].dur_close = close_durations[SLOT_BITS*i +: COUNT_BITS];
    assign ctl[i].dur_open  = open_durations[SLOT_BITS*i +: COUNT_BITS];

    sbd_switch u_sw (
      .clk     (clk),
      .rst     (rst),
      .advance (accept),
      .ctl     (ctl[i]),
      .res     (res[i])
    );
  end

  // Shown bits and notes from the cell requests
  always_comb begin
    shown_next = shown_contacts;
    notes      = '0;
    for (int i = 0; i < NUM_SWITCHES; i++) begin
      if (res[i].show_we) shown_next[i] = res[i].show_open;
      notes[i] = res[i].show_note && notify_mask[i];
    end
  end

  // Safe/active pair machine
  always_comb begin
    pm              = pair_mode;
    pair_mode_next  = pair_mode;
    pair_ticks_next = pair_ticks_left;
    went_active     = 1'b0;
    went_safe       = 1'b0;
    if (is_tick) begin
      if (pair_mode == PR_DEBOUNCE && pair_ticks_left != '0) begin
        pair_ticks_next = pair_ticks_left - PAIR_BITS'(1);
        if (pair_ticks_left == PAIR_BITS'(1)) pair_mode_next = PR_ACTIVE;
      end
    end else if (scan.change_word[BIT_SAFE] || scan.change_word[BIT_ACTIVE]) begin
      // swb is {safe, active}; 1 means open
      if (pm == PR_UNDEF && swb == 2'b01) pm = PR_SAFE;
      pair_mode_next = pm;
      unique case (pm)
        PR_SAFE: begin
          if (swb == 2'b10) begin
            pair_ticks_next = pair_debounce_ticks;
            pair_mode_next  = PR_DEBOUNCE;
            went_active     = 1'b1;
          end
        end
        PR_DEBOUNCE: begin
          if (!swb[1]) begin
            pair_mode_next = PR_SAFE;
            went_safe      = 1'b1;
          end
        end
        PR_ACTIVE: begin
          if (swb != 2'b10) begin
            pair_mode_next = PR_SAFE;
            went_safe      = 1'b1;
          end
        end
        default: pair_mode_next = pm;
      endcase
    end
  end

  // Bank and pair state
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_contacts    <= '0;
      shown_contacts  <= '0;
      pair_mode       <= PR_UNDEF;
      pair_ticks_left <= '0;
    end else if (accept) begin
      raw_contacts    <= is_tick ? raw_contacts : raw_next;
      shown_contacts  <= shown_next;
      pair_mode       <= pair_mode_next;
      pair_ticks_left <= pair_ticks_next;
    end
  end

  // Status register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (status.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status.shown_state      <= shown_next;
      status.notify_bits      <= notes;
      status.pair_active      <= (pair_mode_next == PR_ACTIVE) ||
                                 (pair_mode_next == PR_DEBOUNCE);
      status.pair_went_active <= went_active;
      status.pair_went_safe   <= went_safe;
    end
  end

  assign status.valid = out_valid;

endmodule

`default_nettype wire

[tb/switch_bank_debouncer_tb.sv]
`default_nettype none

module switch_bank_debouncer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sbd_pkg::*;

  localparam int IDLE_LIMIT = 500;
  localparam int RAND_PHASES = 8;
  localparam int WORDS_PER_PHASE = 240;
  localparam logic [WORD_BITS-1:0] SAFE_M = WORD_BITS'(1) << BIT_SAFE;
  localparam logic [WORD_BITS-1:0] ACT_M = WORD_BITS'(1) << BIT_ACTIVE;

  typedef struct packed {
    logic [WORD_BITS-1:0] shown;
    logic [WORD_BITS-1:0] notes;
    logic                 active;
    logic                 went_active;
    logic                 went_safe;
  } bank_status_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [DUR_BITS-1:0] cfg_data;

  sbd_in_if scan_ch ();
  sbd_out_if stat_ch ();

  switch_bank_debouncer u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .scan      (scan_ch),
    .status    (stat_ch)
  );

  // Clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Predicted bank configuration
  logic [WORD_BITS-1:0] bank_enabled;
  logic [WORD_BITS-1:0] bank_wait;
  logic [WORD_BITS-1:0] bank_notify;
  logic [DUR_BITS-1:0] bank_close_dur;
  logic [DUR_BITS-1:0] bank_open_dur;
  logic [PAIR_BITS-1:0] bank_pair_ticks;

  // Predicted bank state
  logic [WORD_BITS-1:0] bank_raw;
  logic [WORD_BITS-1:0] bank_shown;
  logic [WORD_BITS-1:0] bank_notes;
  phase_t bank_phase [NUM_SWITCHES];
  logic [COUNT_BITS-1:0] bank_left [NUM_SWITCHES];
  pair_mode_t bank_pair;
  logic [PAIR_BITS-1:0] bank_pair_left;

  logic [WORD_BITS-1:0] scan_words [$];
  bank_status_t status_due [$];

  int mismatches = 0;
  int words_sent = 0;
  int status_seen = 0;
  int activations = 0;
  int safe_returns = 0;
  int settings = 0;
  int drv_gap = 0;
  int mon_gap = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;

  function automatic void set_shown(int i, logic open_v);
    bank_shown[i] = open_v;
    if (bank_notify[i]) bank_notes[i] = 1'b1;
  endfunction

  // Next status of the bank for one scan word; updates predicted state
  function automatic bank_status_t advance_bank(logic [WORD_BITS-1:0] cw);
    bank_status_t r;
    logic [1:0] swb;
    logic wa;
    logic ws;
    logic [COUNT_BITS-1:0] dc;
    logic [COUNT_BITS-1:0] dopn;
    bank_notes = '0;
    wa = 1'b0;
    ws = 1'b0;
    if (cw == '0) begin
      // time tick: pair count, then each debouncing switch
      if (bank_pair == PR_DEBOUNCE && bank_pair_left != 0) begin
        bank_pair_left = bank_pair_left - 1'b1;
        if (bank_pair_left == 0) bank_pair = PR_ACTIVE;
      end
      for (int i = 0; i < NUM_SWITCHES; i++) begin
        if (bank_enabled[i] && (bank_phase[i] == PH_OPENING || bank_phase[i] == PH_CLOSING)) begin
          if (bank_left[i] != 0) bank_left[i] = bank_left[i] - 1'b1;
          if (bank_left[i] == 0) begin
            if (!bank_raw[i]) begin
              if ((bank_phase[i] == PH_OPENING) != bank_wait[i]) set_shown(i, 1'b0);
              bank_phase[i] = PH_CLOSED;
            end else begin
              if ((bank_phase[i] == PH_CLOSING) != bank_wait[i]) set_shown(i, 1'b1);
              bank_phase[i] = PH_OPEN;
            end
          end
        end
      end
    end else begin
      bank_raw = bank_raw ^ cw;
      // safe/active pair
      if (cw[BIT_SAFE] || cw[BIT_ACTIVE]) begin
        swb = {bank_raw[BIT_SAFE], bank_raw[BIT_ACTIVE]};
        if (bank_pair == PR_UNDEF && swb == 2'b01) bank_pair = PR_SAFE;
        if (bank_pair == PR_SAFE && swb == 2'b10) begin
          bank_pair_left = bank_pair_ticks;
          bank_pair = PR_DEBOUNCE;
          wa = 1'b1;
        end else if (bank_pair == PR_DEBOUNCE) begin
          if (!swb[1]) begin
            bank_pair = PR_SAFE;
            ws = 1'b1;
          end
        end else if (bank_pair == PR_ACTIVE) begin
          if (swb != 2'b10) begin
            bank_pair = PR_SAFE;
            ws = 1'b1;
          end
        end
      end
      // toggled switches
      for (int i = 0; i < NUM_SWITCHES; i++) begin
        if (cw[i] && bank_enabled[i]) begin
          dc = bank_close_dur[SLOT_BITS*i +: COUNT_BITS];
          dopn = bank_open_dur[SLOT_BITS*i +: COUNT_BITS];
          case (bank_phase[i])
            PH_OPEN: begin
              if (!bank_raw[i]) begin
                if (dc == 0) begin
                  set_shown(i, 1'b0);
                  bank_phase[i] = PH_CLOSED;
                end else begin
                  if (!bank_wait[i]) set_shown(i, 1'b0);
                  bank_phase[i] = PH_CLOSING;
                  bank_left[i] = dc;
                end
              end else begin
                bank_shown[i] = 1'b1;
              end
            end
            PH_CLOSED: begin
              if (bank_raw[i]) begin
                if (dopn == 0) begin
                  set_shown(i, 1'b1);
                  bank_phase[i] = PH_OPEN;
                end else begin
                  if (!bank_wait[i]) set_shown(i, 1'b1);
                  bank_phase[i] = PH_OPENING;
                  bank_left[i] = dopn;
                end
              end else begin
                bank_shown[i] = 1'b0;
              end
            end
            PH_OPENING: bank_left[i] = dopn;
            default: bank_left[i] = dc;
          endcase
        end
      end
    end
    r.shown = bank_shown;
    r.notes = bank_notes;
    r.active = (bank_pair == PR_ACTIVE || bank_pair == PR_DEBOUNCE);
    r.went_active = wa;
    r.went_safe = ws;
    return r;
  endfunction

  // Mostly ticks and single toggles so switches get to settle
  function automatic logic [WORD_BITS-1:0] rand_word();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return '0;
      4, 5: return WORD_BITS'(1) << $urandom_range(0, NUM_SWITCHES - 1);
      6: begin
        case ($urandom_range(0, 2))
          0: return SAFE_M;
          1: return ACT_M;
          default: return SAFE_M | ACT_M;
        endcase
      end
      7: return (WORD_BITS'($urandom) & ~(SAFE_M | ACT_M)) | SAFE_M;
      default: return WORD_BITS'($urandom);
    endcase
  endfunction

  function automatic void compare_field(string name, logic [WORD_BITS-1:0] want,
                                        logic [WORD_BITS-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic write_reg(input cfg_reg_t idx, input logic [DUR_BITS-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ENABLED: bank_enabled = v[WORD_BITS-1:0];
      REG_WAIT_MODE: bank_wait = v[WORD_BITS-1:0];
      REG_NOTIFY: bank_notify = v[WORD_BITS-1:0];
      REG_CLOSE_DUR: bank_close_dur = v;
      REG_OPEN_DUR: bank_open_dur = v;
      REG_PAIR_TICKS: bank_pair_ticks = v[PAIR_BITS-1:0];
      default: ;
    endcase
  endtask

  // Hold off until every scan word is in and every status is out
  task automatic drain();
    @(negedge clk);
    while (scan_words.size() != 0 || scan_ch.valid || status_due.size() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Scan driver
  always @(posedge clk) begin
    if (rst) begin
      scan_ch.valid <= 1'b0;
      drv_gap = 0;
    end else begin
      if (scan_ch.valid && scan_ch.ready) begin
        status_due.push_back(advance_bank(scan_ch.change_word));
        words_sent++;
      end
      if (!scan_ch.valid || scan_ch.ready) begin
        if (drv_gap != 0) begin
          drv_gap--;
          scan_ch.valid <= 1'b0;
        end else if (scan_words.size() != 0 && !calm && $urandom_range(0, 9) == 0) begin
          drv_gap = $urandom_range(0, 4);
          scan_ch.valid <= 1'b0;
        end else if (scan_words.size() != 0) begin
          scan_ch.valid <= 1'b1;
          scan_ch.change_word <= scan_words.pop_front();
        end else begin
          scan_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Status monitor and checker
  always @(posedge clk) begin
    bank_status_t e;
    if (rst) begin
      stat_ch.ready <= 1'b0;
      mon_gap = 0;
    end else begin
      if (stat_ch.valid && stat_ch.ready) begin
        status_seen++;
        if (status_due.size() == 0) begin
          $display("%0t: status transfer with nothing expected, expected none got shown %h",
                   $time, stat_ch.shown_state);
          mismatches++;
        end else begin
          e = status_due.pop_front();
          compare_field("shown_state", e.shown, stat_ch.shown_state);
          compare_field("notify_bits", e.notes, stat_ch.notify_bits);
          compare_field("pair_active", e.active, stat_ch.pair_active);
          compare_field("pair_went_active", e.went_active, stat_ch.pair_went_active);
          compare_field("pair_went_safe", e.went_safe, stat_ch.pair_went_safe);
          if (e.went_active) activations++;
          if (e.went_safe) safe_returns++;
        end
      end
      if (mon_gap != 0) begin
        mon_gap--;
        stat_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        mon_gap = $urandom_range(0, 4);
        stat_ch.ready <= 1'b0;
      end else begin
        stat_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on transfer activity
  always @(posedge clk) begin
    if (rst || (scan_ch.valid && scan_ch.ready) || (stat_ch.valid && stat_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d status still due",
               $time, idle_cycles, status_due.size());
      $display("switch_bank_debouncer: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus
  initial begin
    logic [WORD_BITS-1:0] pair_words [8] = '{16'h0040, 16'h00C0, 16'h0000, 16'h0000,
                                             16'h0001, 16'h0040, 16'hFFFF, 16'h8000};
    logic [WORD_BITS-1:0] bank_words [10] = '{16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
                                              16'h0080, 16'h0000, 16'h0000, 16'h0080,
                                              16'h5555, 16'h0000};
    int dmode;
    logic [DUR_BITS-1:0] cd;
    logic [DUR_BITS-1:0] od;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    scan_ch.valid = 1'b0;
    scan_ch.change_word = '0;
    stat_ch.ready = 1'b0;

    bank_enabled = '0;
    bank_wait = '0;
    bank_notify = '0;
    bank_close_dur = '0;
    bank_open_dur = '0;
    bank_pair_ticks = PAIR_TICKS_RESET;
    bank_raw = '0;
    bank_shown = '0;
    bank_notes = '0;
    bank_pair = PR_UNDEF;
    bank_pair_left = '0;
    foreach (bank_phase[i]) begin
      bank_phase[i] = PH_CLOSED;
      bank_left[i] = '0;
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: pair walk through safe, active and back, raw toggles only
    @(negedge clk);
    foreach (pair_words[k]) scan_words.push_back(pair_words[k]);
    repeat (4) scan_words.insert(4, 16'h0000);
    drain();

    // all switches on, mixed modes, zero slots in both durations, zero pair debounce
    write_reg(REG_ENABLED, 64'hFFFF);
    write_reg(REG_WAIT_MODE, 64'h00FF);
    write_reg(REG_NOTIFY, 64'hF0F0);
    write_reg(REG_CLOSE_DUR, 64'hFEDC_BA98_7654_3210);
    write_reg(REG_OPEN_DUR, 64'h0123_4567_89AB_CDEF);
    write_reg(REG_PAIR_TICKS, 64'h0);
    settings++;
    @(negedge clk);
    foreach (bank_words[k]) scan_words.push_back(bank_words[k]);
    drain();

    // durations cleared mid-debounce: reload to zero, then a tick ends it
    write_reg(REG_CLOSE_DUR, 64'h0);
    write_reg(REG_OPEN_DUR, 64'h0);
    @(negedge clk);
    scan_words.push_back(16'hFFFF);
    scan_words.push_back(16'h0000);
    drain();

    // toggle a disabled switch, re-enable, toggle back to its settled value
    write_reg(REG_ENABLED, 64'hFFFE);
    @(negedge clk);
    scan_words.push_back(16'h0001);
    drain();
    write_reg(REG_ENABLED, 64'hFFFF);
    @(negedge clk);
    scan_words.push_back(16'h0001);
    drain();

    // random phases, each with its own settings
    for (int p = 0; p < RAND_PHASES; p++) begin
      cd = {$urandom, $urandom};
      od = {$urandom, $urandom};
      dmode = (p == 0) ? 1 : (p == 1) ? 4 : (p == 2) ? 5 : $urandom_range(0, 3);
      case (dmode)
        1: begin
          cd &= {16{4'h3}};
          od &= {16{4'h3}};
        end
        2: begin
          cd &= {16{4'h1}};
          od &= {16{4'h1}};
        end
        4: begin
          cd = '1;
          od = '1;
        end
        5: begin
          cd = '0;
          od = '0;
        end
        default: ;
      endcase
      if (p == 1) begin
        write_reg(REG_ENABLED, 64'hFFFF);
        write_reg(REG_WAIT_MODE, 64'hFFFF);
        write_reg(REG_NOTIFY, 64'hFFFF);
        write_reg(REG_PAIR_TICKS, 64'h7);
      end else begin
        write_reg(REG_ENABLED, 64'(WORD_BITS'($urandom) | WORD_BITS'($urandom)));
        write_reg(REG_WAIT_MODE, 64'(WORD_BITS'($urandom)));
        write_reg(REG_NOTIFY, 64'(WORD_BITS'($urandom)));
        write_reg(REG_PAIR_TICKS, (p == 0) ? 64'h0 : 64'($urandom_range(0, 7)));
      end
      write_reg(REG_CLOSE_DUR, cd);
      write_reg(REG_OPEN_DUR, od);
      settings++;
      calm = (p == RAND_PHASES - 1);
      @(negedge clk);
      repeat (WORDS_PER_PHASE) scan_words.push_back(rand_word());
      drain();
    end

    // late status would show up here as unexpected
    repeat (5) @(posedge clk);
    $display("covered %0d scan words and %0d status transfers over %0d bank settings",
             words_sent, status_seen, settings);
    $display("pair went active %0d times and back to safe %0d times",
             activations, safe_returns);
    if (mismatches == 0) begin
      $display("switch_bank_debouncer: match");
    end else begin
      $display("switch_bank_debouncer: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
rtl/sbd_pkg.sv
rtl/sbd_if.sv
rtl/sbd_switch.sv
rtl/switch_bank_debouncer.sv
tb/switch_bank_debouncer_tb.sv
